// ===== hdl/imm_pkg.sv =====
// ----------------------------------------------------------------------------
// imm_pkg
// shared types, constants and helpers for the integer matrix multiply block
// ----------------------------------------------------------------------------
package imm_pkg;

	localparam int MAX_DIM_DEF      = 8;
	localparam int ELEMENT_BITS_DEF = 16;

	localparam int IDX_W  = 3;   // row and column port width
	localparam int SIZE_W = 4;   // size register width
	localparam int SUM_W  = 35;  // dot product width
	localparam int CFG_W  = 2;   // register index width

	typedef enum logic [1:0] {
		OP_WRITE_A = 2'd0,
		OP_WRITE_B = 2'd1,
		OP_COMPUTE = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [CFG_W-1:0] {
		REG_ROWS_OF_A  = 2'd0,
		REG_INNER_SIZE = 2'd1,
		REG_COLS_OF_B  = 2'd2,
		REG_UNUSED     = 2'd3
	} reg_idx_t;

	// control token that walks down the cell chain with each A element
	typedef struct packed {
		logic             valid;
		logic             first;   // first term of a dot product
		logic             lastt;   // final term of a dot product
		logic [IDX_W-1:0] t;       // inner index
		logic [IDX_W-1:0] row;     // row of C
	} tok_t;

	// size register clamped into 1..max_dim
	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s,
		input logic [SIZE_W-1:0] max_dim);
		logic [SIZE_W-1:0] r;
		r = s;
		if (s == '0) begin
			r = SIZE_W'(1);
		end else if (s > max_dim) begin
			r = max_dim;
		end
		return r;
	endfunction

endpackage

// ===== hdl/imm_mac_cell.sv =====
// ----------------------------------------------------------------------------
// imm_mac_cell
// one column of B and a multiply-accumulate; forwards the A stream to its neighbor
// ----------------------------------------------------------------------------
module imm_mac_cell
	import imm_pkg::*;
#(
	parameter int MAX_DIM      = MAX_DIM_DEF,
	parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           b_we,
	input  logic [IDX_W-1:0]               b_row,
	input  logic signed [ELEMENT_BITS-1:0] b_data,
	input  tok_t                           tok_in,
	input  logic signed [ELEMENT_BITS-1:0] a_in,
	output tok_t                           tok_out,
	output logic signed [ELEMENT_BITS-1:0] a_out,
	output logic                           res_valid,
	output logic [IDX_W-1:0]               res_row,
	output logic [SUM_W-1:0]               res_value
);

	localparam int BI_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	logic signed [ELEMENT_BITS-1:0]   b_col_q [MAX_DIM];
	logic signed [2*ELEMENT_BITS-1:0] prod;
	logic [SUM_W-1:0]                 acc_q;
	logic [SUM_W-1:0]                 acc_next;
	tok_t                             tok_q;
	logic signed [ELEMENT_BITS-1:0]   a_q;
	logic                             res_valid_q;
	logic [IDX_W-1:0]                 res_row_q;
	logic [SUM_W-1:0]                 res_value_q;

	always_ff @(posedge clk) begin
		if (b_we) begin
			b_col_q[b_row[BI_W-1:0]] <= b_data;
		end
	end

	assign prod     = a_in * b_col_q[tok_in.t[BI_W-1:0]];
	assign acc_next = (tok_in.first ? '0 : acc_q) + SUM_W'(prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			tok_q       <= tok_in;
			res_valid_q <= tok_in.valid && tok_in.lastt;
		end
	end

	always_ff @(posedge clk) begin
		a_q <= a_in;
		if (tok_in.valid) begin
			acc_q <= acc_next;
		end
		if (tok_in.valid && tok_in.lastt) begin
			res_value_q <= acc_next;
			res_row_q   <= tok_in.row;
		end
	end

	assign tok_out   = tok_q;
	assign a_out     = a_q;
	assign res_valid = res_valid_q;
	assign res_row   = res_row_q;
	assign res_value = res_value_q;

endmodule

// ===== hdl/integer_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// signed integer matrix product C = A x B on a chain of multiply-accumulate cells
// ----------------------------------------------------------------------------
// Element writes (op 0 for A, op 1 for B) are taken one per cycle while busy
// is low and leave busy low. A compute transaction raises busy; with n, m, k
// the clamped row, inner and column sizes, the block reads one A element per
// cycle from its A memory and sizes the slot of each row of C in the cell chain
// by the larger of m and k. Results come out row-major, one per cycle at most,
// each for exactly one cycle marked by out_valid; the receiver cannot stall, so
// it must take every result as it appears. The final element carries last, and
// busy drops at the edge that ends that cycle.
// Each cell holds one column of B; A elements flow down the chain one cell per
// cycle, so column j finishes in the cycle after column j-1 and the outputs line
// up in order with no reordering buffer.
// ----------------------------------------------------------------------------
module integer_matrix_multiply
	import imm_pkg::*;
#(
	parameter int MAX_DIM      = MAX_DIM_DEF,
	parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// command transaction
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              op,
	input  logic [IDX_W-1:0]        row_index,
	input  logic [IDX_W-1:0]        col_index,
	input  logic signed [15:0]      element,
	// configuration
	input  logic                    cfg_write,
	input  logic [CFG_W-1:0]        cfg_index,
	input  logic [SIZE_W-1:0]       cfg_data,
	// results
	output logic                    out_valid,
	output logic [IDX_W-1:0]        out_row,
	output logic [IDX_W-1:0]        out_col,
	output logic signed [SUM_W-1:0] product_value,
	output logic                    last
);

	localparam int BI_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_DIM);

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	// configuration registers
	logic [SIZE_W-1:0] rows_q, inner_q, cols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= SIZE_W'(8);
			inner_q <= SIZE_W'(8);
			cols_q  <= SIZE_W'(8);
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ROWS_OF_A:  rows_q  <= cfg_data;
				REG_INNER_SIZE: inner_q <= cfg_data;
				REG_COLS_OF_B:  cols_q  <= cfg_data;
				default:        ;
			endcase
		end
	end

	// accepted command decode
	logic                           take;
	logic                           idx_ok;
	logic                           wr_a, wr_b, go;
	logic signed [ELEMENT_BITS-1:0] elem_w;

	assign take   = start && !busy;
	assign idx_ok = (SIZE_W'(row_index) < MAX_SIZE) && (SIZE_W'(col_index) < MAX_SIZE);
	assign wr_a   = take && idx_ok && (op_t'(op) == OP_WRITE_A);
	assign wr_b   = take && idx_ok && (op_t'(op) == OP_WRITE_B);
	assign go     = take && (op_t'(op) == OP_COMPUTE);
	assign elem_w = ELEMENT_BITS'(element);

	// A memory, one write and one registered read per cycle
	logic signed [ELEMENT_BITS-1:0] a_mem [MAX_DIM][MAX_DIM];
	logic signed [ELEMENT_BITS-1:0] a_s1;

	// sequencer
	state_t            state_q;
	logic              busy_q;
	logic [BI_W-1:0]   i_q, p_q;
	logic [SIZE_W-1:0] n_q, m_q, k_q, per_q;
	tok_t              tok_s1;
	logic [SIZE_W-1:0] m_c, k_c;
	logic              fin;

	assign m_c = clamp_size(inner_q, MAX_SIZE);
	assign k_c = clamp_size(cols_q, MAX_SIZE);

	always_ff @(posedge clk) begin
		if (wr_a) begin
			a_mem[row_index[BI_W-1:0]][col_index[BI_W-1:0]] <= elem_w;
		end
		a_s1 <= a_mem[i_q][p_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			i_q     <= '0;
			p_q     <= '0;
			n_q     <= SIZE_W'(1);
			m_q     <= SIZE_W'(1);
			k_q     <= SIZE_W'(1);
			per_q   <= SIZE_W'(1);
			tok_s1  <= '0;
		end else begin
			if (fin) begin
				busy_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					tok_s1 <= '0;
					if (go) begin
						state_q <= ST_RUN;
						busy_q  <= 1'b1;
						i_q     <= '0;
						p_q     <= '0;
						n_q     <= clamp_size(rows_q, MAX_SIZE);
						m_q     <= m_c;
						k_q     <= k_c;
						per_q   <= (m_c > k_c) ? m_c : k_c;
					end
				end
				ST_RUN: begin
					tok_s1 <= '{
						valid: (SIZE_W'(p_q) < m_q),
						first: (p_q == '0),
						lastt: (SIZE_W'(p_q) == m_q - SIZE_W'(1)),
						t:     IDX_W'(p_q),
						row:   IDX_W'(i_q)
					};
					if (SIZE_W'(p_q) == per_q - SIZE_W'(1)) begin
						p_q <= '0;
						if (SIZE_W'(i_q) == n_q - SIZE_W'(1)) begin
							state_q <= ST_IDLE;
						end else begin
							i_q <= i_q + BI_W'(1);
						end
					end else begin
						p_q <= p_q + BI_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
					tok_s1  <= '0;
				end
			endcase
		end
	end

	assign busy = busy_q;

	// cell chain, cell j holds column j of B
	tok_t                           tok_c [MAX_DIM+1];
	logic signed [ELEMENT_BITS-1:0] a_c   [MAX_DIM+1];
	logic [MAX_DIM-1:0]             res_v;
	logic [IDX_W-1:0]               res_r [MAX_DIM];
	logic [SUM_W-1:0]               res_d [MAX_DIM];

	assign tok_c[0] = tok_s1;
	assign a_c[0]   = a_s1;

	for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
		imm_mac_cell #(
			.MAX_DIM      (MAX_DIM),
			.ELEMENT_BITS (ELEMENT_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.b_we      (wr_b && (col_index[BI_W-1:0] == BI_W'(j))),
			.b_row     (row_index),
			.b_data    (elem_w),
			.tok_in    (tok_c[j]),
			.a_in      (a_c[j]),
			.tok_out   (tok_c[j+1]),
			.a_out     (a_c[j+1]),
			.res_valid (res_v[j]),
			.res_row   (res_r[j]),
			.res_value (res_d[j])
		);
	end

	// at most one cell inside the active columns finishes in a cycle
	logic [MAX_DIM-1:0] res_m;
	logic               pick_v;
	logic [IDX_W-1:0]   pick_r, pick_c;
	logic [SUM_W-1:0]   pick_d;

	always_comb begin
		pick_v = 1'b0;
		pick_r = '0;
		pick_c = '0;
		pick_d = '0;
		for (int j = 0; j < MAX_DIM; j++) begin
			res_m[j] = res_v[j] && (SIZE_W'(j) < k_q);
			if (res_m[j]) begin
				pick_v = 1'b1;
				pick_r = res_r[j];
				pick_c = IDX_W'(j);
				pick_d = res_d[j];
			end
		end
	end

	logic             out_valid_q, last_q;
	logic [IDX_W-1:0] out_row_q, out_col_q;
	logic [SUM_W-1:0] out_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			out_valid_q <= pick_v;
			last_q      <= pick_v && (SIZE_W'(pick_r) == n_q - SIZE_W'(1))
				&& (SIZE_W'(pick_c) == k_q - SIZE_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		out_row_q <= pick_r;
		out_col_q <= pick_c;
		out_val_q <= pick_d;
	end

	assign fin           = out_valid_q && last_q;
	assign out_valid     = out_valid_q;
	assign out_row       = out_row_q;
	assign out_col       = out_col_q;
	assign product_value = out_val_q;
	assign last          = last_q;

`ifndef SYNTHESIS
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> busy)
		else $error("result transaction while not busy");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |=> !busy)
		else $error("busy held after last result");
	a_go_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (op == OP_COMPUTE) |=> busy)
		else $error("compute transaction did not raise busy");
	a_one_res: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(res_m))
		else $error("two cells finished in one cycle");
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> busy_q)
		else $error("sequencer running while not busy");
`endif

endmodule
